/* rtl/core/tsi_pkg.sv */
// Shared package of the time series interpolator: widths, codes, payload
// types and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package tsi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int TIME_W = 44;
	localparam int VAL_W = 40;
	localparam int RES_W = 41;
	localparam int WIN_W = 24;
	localparam int PROD_W = TIME_W + VAL_W;
	localparam int REM_W = TIME_W + 1;
	localparam int MCNT_W = $clog2(VAL_W);
	localparam int DCNT_W = $clog2(PROD_W);
	localparam logic [WIN_W-1:0] WIN_RESET = 24'd60999;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_POINT  = 2'd2,
		CMD_PERIOD = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_FULL  = 2'd2,
		ST_DUP   = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [TIME_W-1:0] time_a;
		logic [TIME_W-1:0] time_b;
		logic [VAL_W-1:0]  reading_value;
	} in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		status_t                 status;
	} out_t;

	typedef struct packed {
		logic [TIME_W-1:0] rtime;
		logic [VAL_W-1:0]  rvalue;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear_tab;
		logic scan_init;
		logic scan_rd;
		logic scan_step;
		logic take_match;
		logic take_prev;
		logic take_zero;
		logic interp_init;
		logic mul_step;
		logic add_half;
		logic div_step;
		logic take_interp;
		logic point_save;
		logic shift_init;
		logic shift_rd;
		logic shift_wr;
		logic ins_write;
		logic set_dup;
		logic set_full;
		logic set_order;
		logic out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic idx_lt_count;
		logic count_zero;
		logic match;
		logic lt;
		logic eq;
		logic idx_zero;
		logic full;
		logic shift_done;
		logic mul_last;
		logic div_last;
		logic second;
		logic ta_gt_tb;
		logic out_busy;
	} ctl_stat_t;

endpackage
`default_nettype wire

/* rtl/core/tsi_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/tsi_ctrl.sv */
// Controller state machine of the time series interpolator.
// Depends on tsi_pkg.
`default_nettype none
module tsi_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tsi_pkg::ctl_stat_t st,
	output tsi_pkg::ctl_cmd_t       cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DECODE   = 13'b0000000000010,
		S_SCAN_RD  = 13'b0000000000100,
		S_SCAN_CHK = 13'b0000000001000,
		S_INS_CHK  = 13'b0000000010000,
		S_SHIFT_RD = 13'b0000000100000,
		S_SHIFT_WR = 13'b0000001000000,
		S_MUL      = 13'b0000010000000,
		S_HALF     = 13'b0000100000000,
		S_DIV      = 13'b0001000000000,
		S_DIV_END  = 13'b0010000000000,
		S_PT_DONE  = 13'b0100000000000,
		S_FINISH   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   is_insert;

	assign is_insert = (st.cmd == tsi_pkg::CMD_INSERT);
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.cmd)
					tsi_pkg::CMD_CLEAR: begin
						cmd.clear_tab = 1'b1;
						state_d = S_FINISH;
					end
					tsi_pkg::CMD_PERIOD: begin
						if (st.ta_gt_tb) begin
							cmd.set_order = 1'b1;
							state_d = S_FINISH;
						end else begin
							cmd.scan_init = 1'b1;
							state_d = S_SCAN_RD;
						end
					end
					default: begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN_RD;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (st.idx_lt_count) begin
					cmd.scan_rd = 1'b1;
					state_d = S_SCAN_CHK;
				end else if (is_insert) begin
					state_d = S_INS_CHK;
				end else begin
					cmd.take_zero = st.count_zero;
					cmd.take_prev = !st.count_zero;
					state_d = S_PT_DONE;
				end
			end
			S_SCAN_CHK: begin
				if (is_insert) begin
					if (st.lt) begin
						cmd.scan_step = 1'b1;
						state_d = S_SCAN_RD;
					end else if (st.eq) begin
						cmd.set_dup = 1'b1;
						state_d = S_FINISH;
					end else begin
						state_d = S_INS_CHK;
					end
				end else if (st.match) begin
					cmd.take_match = 1'b1;
					state_d = S_PT_DONE;
				end else if (st.lt) begin
					cmd.scan_step = 1'b1;
					state_d = S_SCAN_RD;
				end else if (st.idx_zero) begin
					// Before the first reading: clamp to it.
					cmd.take_match = 1'b1;
					state_d = S_PT_DONE;
				end else begin
					cmd.interp_init = 1'b1;
					state_d = S_MUL;
				end
			end
			S_INS_CHK: begin
				if (st.full) begin
					cmd.set_full = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.shift_init = 1'b1;
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (st.shift_done) begin
					cmd.ins_write = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (st.mul_last) begin
					state_d = S_HALF;
				end
			end
			S_HALF: begin
				cmd.add_half = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				cmd.take_interp = 1'b1;
				state_d = S_PT_DONE;
			end
			S_PT_DONE: begin
				if (st.cmd == tsi_pkg::CMD_PERIOD && !st.second) begin
					cmd.point_save = 1'b1;
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/tsi_dp.sv */
// Datapath of the time series interpolator: reading table, scan registers,
// serial multiplier and divider, and the output register.
// Depends on tsi_pkg and tsi_ram.
`default_nettype none
module tsi_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tsi_pkg::in_t                 in_data,
	output tsi_pkg::out_t                     out_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	input  wire logic                         cfg_we,
	input  wire logic [tsi_pkg::WIN_W-1:0]    cfg_wdata,
	input  wire tsi_pkg::ctl_cmd_t            cmd,
	output tsi_pkg::ctl_stat_t                st
);

	localparam int AW = tsi_pkg::ADDR_W;
	localparam int CW = tsi_pkg::CNT_W;
	localparam int TW = tsi_pkg::TIME_W;
	localparam int VW = tsi_pkg::VAL_W;
	localparam int PW = tsi_pkg::PROD_W;
	localparam int RW = tsi_pkg::REM_W;
	localparam int EW = $bits(tsi_pkg::entry_t);

	tsi_pkg::in_t             in_q;
	tsi_pkg::status_t         status_q;
	tsi_pkg::out_t            out_q;
	tsi_pkg::entry_t          rdata, wdata;
	logic [tsi_pkg::WIN_W-1:0] win_q;
	logic [CW-1:0]            count_q, idx_q, j_q;
	logic [TW-1:0]            t_q, p_time_q, dt_q, span_q, gap;
	logic [VW-1:0]            p_val_q, mag_q, mag_sh_q, pt_q, first_q, q_clamp;
	logic                     second_q, up_q, out_valid_q;
	logic [PW-1:0]            acc_q;
	logic [RW-1:0]            rem_q, rem_sh;
	logic [tsi_pkg::MCNT_W-1:0] mcnt_q;
	logic [tsi_pkg::DCNT_W-1:0] dcnt_q;
	logic                     we, ge;
	logic [AW-1:0]            waddr, raddr;
	logic [CW-1:0]            j_m1;
	logic [tsi_pkg::RES_W-1:0] res;

	// Reading table.
	tsi_ram #(
		.WIDTH(EW),
		.DEPTH(tsi_pkg::TABLE_DEPTH)
	) u_tab (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign j_m1 = j_q - CW'(1);
	assign raddr = cmd.shift_rd ? j_m1[AW-1:0] : idx_q[AW-1:0];
	assign we = cmd.shift_wr || cmd.ins_write;
	assign waddr = cmd.shift_wr ? j_q[AW-1:0] : idx_q[AW-1:0];
	assign wdata = cmd.shift_wr ? rdata : tsi_pkg::entry_t'{in_q.time_a, in_q.reading_value};

	// Compare of the read entry against the query time.
	assign gap = (rdata.rtime >= t_q) ? rdata.rtime - t_q : t_q - rdata.rtime;
	assign rem_sh = {rem_q[RW-2:0], acc_q[PW-1]};
	assign ge = rem_sh >= RW'(span_q);
	assign q_clamp = (acc_q > PW'(mag_q)) ? mag_q : acc_q[VW-1:0];

	assign st.cmd = in_q.command;
	assign st.idx_lt_count = idx_q < count_q;
	assign st.count_zero = (count_q == '0);
	assign st.match = gap <= TW'(win_q);
	assign st.lt = rdata.rtime < t_q;
	assign st.eq = rdata.rtime == t_q;
	assign st.idx_zero = (idx_q == '0);
	assign st.full = (count_q == CW'(tsi_pkg::TABLE_DEPTH));
	assign st.shift_done = (j_q == idx_q);
	assign st.mul_last = (mcnt_q == tsi_pkg::MCNT_W'(VW - 1));
	assign st.div_last = (dcnt_q == tsi_pkg::DCNT_W'(PW - 1));
	assign st.second = second_q;
	assign st.ta_gt_tb = in_q.time_a > in_q.time_b;
	assign st.out_busy = out_valid_q && out_stall;

	// Result of the item.
	always_comb begin
		res = '0;
		if (status_q == tsi_pkg::ST_OK) begin
			case (in_q.command)
				tsi_pkg::CMD_POINT: res = {1'b0, pt_q};
				tsi_pkg::CMD_PERIOD: res = {1'b0, first_q} - {1'b0, pt_q};
				default: res = '0;
			endcase
		end
	end

	// Control registers: window, fill count, output valid, status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= tsi_pkg::WIN_RESET;
			count_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= tsi_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (cmd.clear_tab) begin
				count_q <= '0;
			end else if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				status_q <= tsi_pkg::ST_OK;
			end else if (cmd.set_dup) begin
				status_q <= tsi_pkg::ST_DUP;
			end else if (cmd.set_full) begin
				status_q <= tsi_pkg::ST_FULL;
			end else if (cmd.set_order) begin
				status_q <= tsi_pkg::ST_ORDER;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= in_data;
		end
		if (cmd.scan_init) begin
			idx_q <= '0;
			second_q <= 1'b0;
			t_q <= (in_q.command == tsi_pkg::CMD_PERIOD) ? in_q.time_b : in_q.time_a;
		end else if (cmd.point_save) begin
			idx_q <= '0;
			second_q <= 1'b1;
			t_q <= in_q.time_a;
			first_q <= pt_q;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
			p_time_q <= rdata.rtime;
			p_val_q <= rdata.rvalue;
		end
		// Point result selection.
		if (cmd.take_zero) begin
			pt_q <= '0;
		end else if (cmd.take_prev) begin
			pt_q <= p_val_q;
		end else if (cmd.take_match) begin
			pt_q <= rdata.rvalue;
		end else if (cmd.take_interp) begin
			pt_q <= up_q ? p_val_q + q_clamp : p_val_q - q_clamp;
		end
		// Table shift on insert.
		if (cmd.shift_init) begin
			j_q <= count_q;
		end else if (cmd.shift_wr) begin
			j_q <= j_m1;
		end
		// Interpolation: serial multiply, rounding add, restoring divide.
		if (cmd.interp_init) begin
			dt_q <= t_q - p_time_q;
			span_q <= rdata.rtime - p_time_q;
			up_q <= rdata.rvalue >= p_val_q;
			mag_q <= (rdata.rvalue >= p_val_q) ? rdata.rvalue - p_val_q
				: p_val_q - rdata.rvalue;
			mag_sh_q <= (rdata.rvalue >= p_val_q) ? rdata.rvalue - p_val_q
				: p_val_q - rdata.rvalue;
			acc_q <= '0;
			mcnt_q <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (mag_sh_q[VW-1] ? PW'(dt_q) : PW'(0));
			mag_sh_q <= {mag_sh_q[VW-2:0], 1'b0};
			mcnt_q <= mcnt_q + tsi_pkg::MCNT_W'(1);
		end else if (cmd.add_half) begin
			acc_q <= acc_q + PW'(span_q >> 1);
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			acc_q <= {acc_q[PW-2:0], ge};
			rem_q <= ge ? rem_sh - RW'(span_q) : rem_sh;
			dcnt_q <= dcnt_q + tsi_pkg::DCNT_W'(1);
		end
		// Output register.
		if (cmd.out_load) begin
			out_q.result_value <= $signed(res);
			out_q.status <= status_q;
		end
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/core/time_series_interpolator_core.sv */
// Top level of the time series interpolator: controller plus datapath.
// Depends on tsi_pkg, tsi_ctrl and tsi_dp.
//
// Usage: one input channel (in_valid, in_stall, in_data) takes a command
// beat: clear, insert reading, point query or period query. Every beat
// gives exactly one result beat on the output channel (out_valid, out_stall,
// out_data) with a value and a status. cfg_we with cfg_wdata writes the match
// window in ms; write it only while the block is idle.
// One beat is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register. Clear resets the fill count;
// insert scans to the slot, then moves each later entry up by a read and a
// write; point query takes the reading at the scan position that matches or
// clamps, the last reading (zero for an empty table) when the scan passes
// the end, or interpolates between two readings; period query works as two
// point queries.
// The table's registered read sets the scan and move rate, the serial
// 40-step multiplier and 84-step divider the interpolation time; the longest
// item is a period query that interpolates twice near the end of a full
// table.
// The output register holds a finished beat while out_stall is high; the
// next beat is accepted meanwhile and waits at its end for the slot to free.
// Reset empties the table and sets the window to 60999 ms; the table memory
// itself is not cleared.
`default_nettype none
module time_series_interpolator_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire tsi_pkg::in_t              in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output tsi_pkg::out_t                  out_data,
	input  wire logic                      cfg_we,
	input  wire logic [tsi_pkg::WIN_W-1:0] cfg_wdata
);

	tsi_pkg::ctl_cmd_t  cmd;
	tsi_pkg::ctl_stat_t st;

	// Sequencer.
	tsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Table, arithmetic and output register.
	tsi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire

/* rtl/core/tsi_checker.sv */
// Port-level checker of the time series interpolator and its bind.
// Depends on tsi_pkg and time_series_interpolator_core.
`default_nettype none
module tsi_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire tsi_pkg::out_t out_data
);

	// An accepted beat keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again straight after a beat");

	// A dropped or rejected item carries a zero value.
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != tsi_pkg::ST_OK |-> out_data.result_value == '0)
		else $error("nonzero value with an error status");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

endmodule

bind time_series_interpolator_core tsi_checker u_tsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
